[rtl/tmcm_pkg.sv]
// Shared types and constants of the trimmed median common mode estimator.
package tmcm_pkg;

    // Offset-corrected pixel value, two's complement.
    localparam int VALUE_W = 15;
    typedef logic signed [VALUE_W-1:0] value_t;

    // Configuration registers, 8 bits each.
    localparam int CFG_W = 8;
    typedef logic [CFG_W-1:0] cfg_t;

    // Configuration register indexes.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SEGMENT_LENGTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_MULTIPLIER = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_PIXELS       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DROP_HIGH        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DROP_LOW         = 3'd4;

    // Register reset values.
    localparam cfg_t RST_SEGMENT_LENGTH   = 8'd128;
    localparam cfg_t RST_NOISE_MULTIPLIER = 8'd64;
    localparam cfg_t RST_MIN_PIXELS       = 8'd8;
    localparam cfg_t RST_DROP_HIGH        = 8'd5;
    localparam cfg_t RST_DROP_LOW         = 8'd0;

    // Field widths of the pixel word.
    localparam int PIX_W   = 14;
    localparam int NOISE_W = 12;
    localparam int PROD_W  = CFG_W + NOISE_W;

    // Insert request broadcast along the sorting chain.
    typedef struct packed {
        logic   en;
        value_t value;
    } ins_t;

    // Sequencer states: accepting pixels, then closing a segment.
    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_KEEP,
        ST_INSERT,
        ST_INDEX,
        ST_GROUP,
        ST_EMIT
    } state_t;

endpackage

[rtl/trimmed_median_common_mode_top.sv]
// Top level of the trimmed median common mode estimator.
// Pixels are taken one word per cycle while in_stall is low; a kept pixel passes stage one and
// stage two before it enters the sorting chain. After the last pixel of a segment the input
// stalls through the KEEP, INSERT, INDEX, GROUP and EMIT states while the chain settles and
// the median is read through the two-level selector; EMIT waits while the output stalls.
// Reset clears counters, sequencer and registers to defaults; sorted values need no clearing.
module trimmed_median_common_mode_top #(
    parameter int MAX_SEGMENT = 128,
    parameter int ADC_BITS    = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_write,
    input  logic [tmcm_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [tmcm_pkg::CFG_W-1:0]        cfg_data,
    // Pixel channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tmcm_pkg::PIX_W-1:0]        raw_pixel,
    input  logic [tmcm_pkg::PIX_W-1:0]        offset_value,
    input  logic [tmcm_pkg::NOISE_W-1:0]      noise_value,
    input  logic                              pixel_good,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [tmcm_pkg::VALUE_W-1:0] common_mode_level,
    output logic                              level_valid,
    output logic [7:0]                        kept_count
);
    import tmcm_pkg::*;

    localparam int KEPT_W   = $clog2(MAX_SEGMENT + 1);
    localparam int IDX_W    = $clog2(MAX_SEGMENT);
    localparam int LEN_CAP  = (MAX_SEGMENT < 255) ? MAX_SEGMENT : 255;
    localparam int POS_W    = $clog2(LEN_CAP + 1);
    localparam int CMP_W    = (KEPT_W > 8) ? KEPT_W : 8;
    localparam int INT_W    = CMP_W + 2;
    localparam int EFF_BITS = (ADC_BITS < PIX_W) ? ADC_BITS : PIX_W;
    localparam logic [PIX_W-1:0] ADC_MASK = PIX_W'((32'd1 << EFF_BITS) - 1);

    // Configuration registers
    cfg_t segment_length_reg;
    cfg_t noise_multiplier_reg;
    cfg_t min_pixels_reg;
    cfg_t drop_high_reg;
    cfg_t drop_low_reg;

    // Sequencer
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   seg_end;
    logic   close_seg;
    logic   index_load;
    logic   emit;

    // Segment counters
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  len_eff;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_after;
    logic [KEPT_W-1:0] seg_kept_reg;

    // Threshold pipeline
    logic              s1_valid_reg;
    logic              s1_good_reg;
    value_t            s1_corr_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s2_keep_reg;
    value_t            s2_val_reg;
    logic signed [23:0] corr_scaled;
    logic signed [23:0] limit;
    logic [PIX_W-1:0]  raw_m;
    logic [PIX_W-1:0]  off_m;
    ins_t              ins;

    // Median index
    logic signed [INT_W-1:0] interest;
    logic signed [INT_W-1:0] idx_sum;
    logic [IDX_W-1:0]        idx_reg;
    logic                    valid_reg;

    // Sorted store and selector
    value_t [MAX_SEGMENT-1:0] cell_vals;
    value_t                   sel_level;

    // Output register
    logic   out_valid_reg;
    value_t level_reg;
    logic   level_valid_reg;
    logic [7:0] kept_count_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_length_reg   <= RST_SEGMENT_LENGTH;
            noise_multiplier_reg <= RST_NOISE_MULTIPLIER;
            min_pixels_reg       <= RST_MIN_PIXELS;
            drop_high_reg        <= RST_DROP_HIGH;
            drop_low_reg         <= RST_DROP_LOW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SEGMENT_LENGTH:   segment_length_reg   <= cfg_data;
                REG_NOISE_MULTIPLIER: noise_multiplier_reg <= cfg_data;
                REG_MIN_PIXELS:       min_pixels_reg       <= cfg_data;
                REG_DROP_HIGH:        drop_high_reg        <= cfg_data;
                REG_DROP_LOW:         drop_low_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective segment length: zero means one, large values saturate.
    always_comb
    begin
        if (segment_length_reg == '0)
        begin
            len_eff = POS_W'(1);
        end
        else if (CMP_W'(segment_length_reg) > CMP_W'(LEN_CAP))
        begin
            len_eff = POS_W'(LEN_CAP);
        end
        else
        begin
            len_eff = POS_W'(segment_length_reg);
        end
    end

    assign accept  = in_valid && !in_stall;
    assign pos_inc = pos_reg + POS_W'(1);
    assign seg_end = pos_inc >= len_eff;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: if (in_valid && seg_end) state_next = ST_KEEP;
            ST_KEEP:   state_next = ST_INSERT;
            ST_INSERT: state_next = ST_INDEX;
            ST_INDEX:  state_next = ST_GROUP;
            ST_GROUP:  state_next = ST_EMIT;
            ST_EMIT:   if (!out_valid_reg || !out_stall) state_next = ST_ACCEPT;
            default:   state_next = ST_ACCEPT;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall   = 1'b1;
        close_seg  = 1'b0;
        index_load = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_ACCEPT: in_stall = 1'b0;
            ST_INSERT: close_seg = 1'b1;
            ST_INDEX:  index_load = 1'b1;
            ST_EMIT:   emit = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pixel position within the segment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= seg_end ? '0 : pos_inc;
        end
    end

    // Stage one: offset correction and the noise limit product.
    assign raw_m = raw_pixel & ADC_MASK;
    assign off_m = offset_value & ADC_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_good_reg <= pixel_good;
        s1_corr_reg <= $signed({1'b0, raw_m}) - $signed({1'b0, off_m});
        s1_prod_reg <= noise_multiplier_reg * noise_value;
    end

    // Stage two: keep a good pixel when the corrected value is below the limit (Q12.8).
    assign corr_scaled = {s1_corr_reg[VALUE_W-1], s1_corr_reg, 8'b0};
    assign limit       = $signed({4'b0, s1_prod_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_keep_reg <= 1'b0;
        end
        else
        begin
            s2_keep_reg <= s1_valid_reg && s1_good_reg && (corr_scaled < limit);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_val_reg <= s1_corr_reg;
    end

    // Insert into the chain while there is room.
    assign ins.en     = s2_keep_reg && (kept_reg < KEPT_W'(MAX_SEGMENT));
    assign ins.value  = s2_val_reg;
    assign kept_after = ins.en ? kept_reg + KEPT_W'(1) : kept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= '0;
        end
        else
        begin
            kept_reg <= close_seg ? '0 : kept_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_seg)
        begin
            seg_kept_reg <= kept_after;
        end
    end

    tmcm_chain #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .KEPT_W      (KEPT_W)
    ) u_chain (
        .clk  (clk),
        .ins  (ins),
        .kept (kept_reg),
        .vals (cell_vals)
    );

    // Trimmed count and the median index; a negative count is too few.
    assign interest = $signed(INT_W'(seg_kept_reg)) - $signed(INT_W'(drop_low_reg))
                      - $signed(INT_W'(drop_high_reg));
    assign idx_sum  = (interest >>> 1) + $signed(INT_W'(drop_low_reg));

    always_ff @(posedge clk)
    begin
        if (index_load)
        begin
            valid_reg <= interest > $signed(INT_W'(min_pixels_reg));
            idx_reg   <= idx_sum[IDX_W-1:0];
        end
    end

    tmcm_select #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .IDX_W       (IDX_W)
    ) u_select (
        .clk   (clk),
        .vals  (cell_vals),
        .idx   (idx_reg),
        .level (sel_level)
    );

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            level_reg       <= valid_reg ? sel_level : '0;
            level_valid_reg <= valid_reg;
            kept_count_reg  <= (CMP_W'(seg_kept_reg) > CMP_W'(255)) ? 8'hFF
                               : 8'(seg_kept_reg);
        end
    end

    assign out_valid         = out_valid_reg;
    assign common_mode_level = level_reg;
    assign level_valid       = level_valid_reg;
    assign kept_count        = kept_count_reg;

endmodule

[rtl/tmcm_cell.sv]
// One cell of the insertion-sorting chain: holds one kept value.
module tmcm_cell #(
    parameter int CELL_IDX = 0,
    parameter int KEPT_W   = 8
) (
    input  logic                 clk,
    input  tmcm_pkg::ins_t       ins,
    input  logic [KEPT_W-1:0]    kept,
    input  tmcm_pkg::value_t     left_val,
    input  logic                 left_gt,
    output tmcm_pkg::value_t     val,
    output logic                 gt
);
    import tmcm_pkg::*;

    value_t val_reg;
    value_t val_next;
    logic   occupied;
    logic   in_reach;

    // A cell is occupied below the fill count; the first free cell is in reach too.
    assign occupied = kept > KEPT_W'(CELL_IDX);
    assign in_reach = kept >= KEPT_W'(CELL_IDX);

    // A free cell acts as larger than any incoming word.
    assign gt = !occupied || (val_reg > ins.value);

    // Shift right where the new word goes ahead of the stored one.
    always_comb
    begin
        val_next = val_reg;
        if (ins.en && in_reach && gt)
        begin
            val_next = left_gt ? left_val : ins.value;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/tmcm_chain.sv]
// Row of sorting cells that keeps the kept values in ascending order.
module tmcm_chain #(
    parameter int MAX_SEGMENT = 128,
    parameter int KEPT_W      = 8
) (
    input  logic                                clk,
    input  tmcm_pkg::ins_t                      ins,
    input  logic [KEPT_W-1:0]                   kept,
    output tmcm_pkg::value_t [MAX_SEGMENT-1:0]  vals
);
    import tmcm_pkg::*;

    value_t [MAX_SEGMENT:0] val_w;
    logic   [MAX_SEGMENT:0] gt_w;

    // The head of the chain has no left neighbor.
    assign val_w[0] = '0;
    assign gt_w[0]  = 1'b0;

    // Each cell hands its value and compare result to the right neighbor.
    for (genvar i = 0; i < MAX_SEGMENT; i++)
    begin : g_cell
        tmcm_cell #(
            .CELL_IDX (i),
            .KEPT_W   (KEPT_W)
        ) u_cell (
            .clk      (clk),
            .ins      (ins),
            .kept     (kept),
            .left_val (val_w[i]),
            .left_gt  (gt_w[i]),
            .val      (val_w[i+1]),
            .gt       (gt_w[i+1])
        );
        assign vals[i] = val_w[i+1];
    end

endmodule

[rtl/tmcm_select.sv]
// Two-level registered selector that reads one sorted cell by index.
module tmcm_select #(
    parameter int MAX_SEGMENT = 128,
    parameter int IDX_W       = 7
) (
    input  logic                                clk,
    input  tmcm_pkg::value_t [MAX_SEGMENT-1:0]  vals,
    input  logic [IDX_W-1:0]                    idx,
    output tmcm_pkg::value_t                    level
);
    import tmcm_pkg::*;

    localparam int LOW_W    = (IDX_W < 5) ? IDX_W : 5;
    localparam int GS       = 1 << LOW_W;
    localparam int NGRP     = (MAX_SEGMENT + GS - 1) / GS;
    localparam int PAD_BITS = NGRP * GS * VALUE_W;

    value_t [NGRP*GS-1:0] padded;
    value_t               grp_reg [NGRP];
    value_t               grp_next [NGRP];
    logic [IDX_W-1:0]     idx_reg;

    // Pad the cell row up to whole groups.
    assign padded = PAD_BITS'(vals);

    // First level: pick the addressed cell inside every group.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GS; j++)
            begin
                if (idx[LOW_W-1:0] == LOW_W'(j))
                begin
                    grp_next[g] = padded[g*GS+j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
        idx_reg <= idx;
    end

    // Second level: pick the addressed group.
    always_comb
    begin
        level = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if ((idx_reg >> LOW_W) == IDX_W'(g))
            begin
                level = grp_reg[g];
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the trimmed median common mode estimator.
module testbench;
    import tmcm_pkg::*;

    localparam int MAX_SEG        = 128;
    localparam int SLOT_W         = $clog2(MAX_SEG);
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int LONG_PHASES    = 3;
    localparam int CALM_PHASE     = 3;
    localparam int PRESSURE_PHASE = 5;

    // First index past the register list; the block must ignore writes there.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    // One pixel word as offered on the input channel.
    typedef struct packed {
        logic [PIX_W-1:0]   raw;
        logic [PIX_W-1:0]   offset;
        logic [NOISE_W-1:0] noise;
        logic               good;
    } pixel_t;

    // One common mode result word.
    typedef struct packed {
        value_t     level;
        logic       valid;
        logic [7:0] count;
    } level_word_t;

    typedef enum logic {ROW_CONFIG, ROW_PIXEL} row_kind_t;

    // A row of the directed table: a register write or a pixel, optionally with its result.
    typedef struct packed {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   index;
        cfg_t                   data;
        pixel_t                 pixel;
        logic                   typed;
        level_word_t            word;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   cfg_index;
    cfg_t                   cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [PIX_W-1:0]       raw_pixel;
    logic [PIX_W-1:0]       offset_value;
    logic [NOISE_W-1:0]     noise_value;
    logic                   pixel_good;
    logic                   out_valid;
    logic                   out_stall;
    value_t                 common_mode_level;
    logic                   level_valid;
    logic [7:0]             kept_count;

    // Common mode predictor state and its copy of the registers.
    value_t      sorted_levels [MAX_SEG];
    int          kept_pixels;
    int          pixel_slot;
    int          seg_length_cfg;
    int          noise_mult_cfg;
    int          min_pixels_cfg;
    int          drop_high_cfg;
    int          drop_low_cfg;
    level_word_t pending_levels [$];

    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;
    bit          hold_done = 1'b0;
    stim_row_t   directed_rows [$];

    trimmed_median_common_mode_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_pixel         (raw_pixel),
        .offset_value      (offset_value),
        .noise_value       (noise_value),
        .pixel_good        (pixel_good),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .common_mode_level (common_mode_level),
        .level_valid       (level_valid),
        .kept_count        (kept_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic stim_row_t cfg_row(logic [REG_IDX_W-1:0] index, cfg_t data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    function automatic stim_row_t pixel_row(int raw, int offset, int noise, bit good);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.pixel.raw = raw[PIX_W-1:0];
        row.pixel.offset = offset[PIX_W-1:0];
        row.pixel.noise = noise[NOISE_W-1:0];
        row.pixel.good = good;
        return row;
    endfunction

    // Pixel row that closes a segment whose result is obvious by hand.
    function automatic stim_row_t checked_row(int raw, int offset, int noise, bit good,
                                              int level, bit valid, int count);
        stim_row_t row;
        row = pixel_row(raw, offset, noise, good);
        row.typed = 1'b1;
        row.word.level = value_t'(level);
        row.word.valid = valid;
        row.word.count = 8'(count);
        return row;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Random pixel: mostly a small correction near the threshold, else any bits at all.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     off_i;
        int     raw_i;
        int     delta;
        px.offset = PIX_W'($urandom_range(0, 16383));
        px.noise = NOISE_W'($urandom_range(0, 4095));
        px.good = ($urandom_range(0, 9) != 0);
        px.raw = PIX_W'($urandom_range(0, 16383));
        if ($urandom_range(0, 9) < 6)
        begin
            off_i = int'(px.offset);
            delta = $urandom_range(0, 128);
            raw_i = off_i + delta - 64;
            if (raw_i < 0)
                raw_i = 0;
            if (raw_i > 16383)
                raw_i = 16383;
            px.raw = raw_i[PIX_W-1:0];
            px.noise = NOISE_W'($urandom_range(0, 1023));
        end
        return px;
    endfunction

    // Advance the common mode prediction by one accepted pixel.
    task automatic track_pixel(input pixel_t px, input logic typed, input level_word_t typed_word);
        int          raw_i;
        int          off_i;
        int          noise_i;
        int          corr;
        int          seg_len;
        int          slot;
        int          j;
        int          interest;
        value_t      corr_v;
        level_word_t word;
        raw_i = int'(px.raw);
        off_i = int'(px.offset);
        noise_i = int'(px.noise);
        corr = raw_i - off_i;
        corr_v = value_t'(corr);
        seg_len = (seg_length_cfg == 0) ? 1 :
                  ((seg_length_cfg > MAX_SEG) ? MAX_SEG : seg_length_cfg);

        // Keep good pixels below the noise threshold, in ascending order.
        if (px.good && corr * 256 < noise_mult_cfg * noise_i && kept_pixels < MAX_SEG)
        begin
            slot = 0;
            while (slot < kept_pixels && sorted_levels[SLOT_W'(slot)] <= corr_v)
                slot++;
            for (j = kept_pixels; j > slot; j--)
                sorted_levels[SLOT_W'(j)] = sorted_levels[SLOT_W'(j - 1)];
            sorted_levels[SLOT_W'(slot)] = corr_v;
            kept_pixels++;
        end

        // At segment end pick the trimmed median, or flag too few pixels.
        pixel_slot++;
        if (pixel_slot >= seg_len)
        begin
            interest = kept_pixels - drop_low_cfg - drop_high_cfg;
            word.level = '0;
            word.valid = 1'b0;
            if (interest > min_pixels_cfg)
            begin
                word.level = sorted_levels[SLOT_W'(interest / 2 + drop_low_cfg)];
                word.valid = 1'b1;
            end
            word.count = 8'(kept_pixels);
            pending_levels.insert(pending_levels.size(), typed ? typed_word : word);
            kept_pixels = 0;
            pixel_slot = 0;
        end
    endtask

    // Offer one pixel word after random idle cycles and wait for it to be taken.
    task automatic send_pixel(input pixel_t px, input logic typed, input level_word_t typed_word);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        raw_pixel <= px.raw;
        offset_value <= px.offset;
        noise_value <= px.noise;
        pixel_good <= px.good;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_pixel(px, typed, typed_word);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] index, input cfg_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            REG_SEGMENT_LENGTH:   seg_length_cfg = int'(data);
            REG_NOISE_MULTIPLIER: noise_mult_cfg = int'(data);
            REG_MIN_PIXELS:       min_pixels_cfg = int'(data);
            REG_DROP_HIGH:        drop_high_cfg = int'(data);
            REG_DROP_LOW:         drop_low_cfg = int'(data);
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop offering pixels, collect every pending result and let the pipeline settle.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result receiver: random stalls, one long hold-off, and a calm phase without stalls.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        level_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected result: level %0d valid %0b count %0d",
                         $time, common_mode_level, level_valid, kept_count);
                mismatches++;
            end
            else
            begin
                want = pending_levels.pop_front();
                if (common_mode_level !== want.level)
                begin
                    $display("%0t: common_mode_level expected %0d, actual %0d",
                             $time, want.level, common_mode_level);
                    mismatches++;
                end
                if (level_valid !== want.valid)
                begin
                    $display("%0t: level_valid expected %0b, actual %0b",
                             $time, want.valid, level_valid);
                    mismatches++;
                end
                if (kept_count !== want.count)
                begin
                    $display("%0t: kept_count expected %0d, actual %0d",
                             $time, want.count, kept_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too many cycles in a row without any word moving ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // Stimulus: reset, the directed table, then randomly configured phases.
    initial
    begin
        bit                   writing;
        int                   phase;
        int                   long_count;
        int                   random_items;
        int                   phase_items;
        cfg_t                 len_v;
        cfg_t                 mult_v;
        cfg_t                 min_v;
        cfg_t                 high_v;
        cfg_t                 low_v;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        raw_pixel = '0;
        offset_value = '0;
        noise_value = '0;
        pixel_good = 1'b0;

        kept_pixels = 0;
        pixel_slot = 0;
        seg_length_cfg = int'(RST_SEGMENT_LENGTH);
        noise_mult_cfg = int'(RST_NOISE_MULTIPLIER);
        min_pixels_cfg = int'(RST_MIN_PIXELS);
        drop_high_cfg = int'(RST_DROP_HIGH);
        drop_low_cfg = int'(RST_DROP_LOW);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset thresholds on a short segment: one pixel kept, trim leaves a negative count.
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd4));
        add_row(pixel_row(16383, 0, 4095, 1'b1));
        add_row(pixel_row(0, 16383, 0, 1'b1));
        add_row(pixel_row(100, 100, 0, 1'b1));
        add_row(checked_row(5, 0, 4095, 1'b0, 0, 1'b0, 1));

        // No trimming, widest threshold, extreme corrections.
        add_row(cfg_row(REG_MIN_PIXELS, 8'd0));
        add_row(cfg_row(REG_DROP_HIGH, 8'd0));
        add_row(cfg_row(REG_DROP_LOW, 8'd0));
        add_row(cfg_row(REG_NOISE_MULTIPLIER, 8'd255));
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd3));
        add_row(pixel_row(0, 16383, 4095, 1'b1));
        add_row(pixel_row(16383, 16383, 1, 1'b1));
        add_row(pixel_row(16, 0, 4095, 1'b1));

        // Remaining count equal to the minimum is still too few.
        add_row(cfg_row(REG_MIN_PIXELS, 8'd2));
        add_row(cfg_row(REG_DROP_HIGH, 8'd1));
        add_row(cfg_row(REG_DROP_LOW, 8'd1));
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd4));
        add_row(pixel_row(10, 0, 4095, 1'b1));
        add_row(pixel_row(0, 5, 4095, 1'b1));
        add_row(pixel_row(3, 0, 4095, 1'b1));
        add_row(checked_row(7, 0, 4095, 1'b1, 0, 1'b0, 4));

        // One above the minimum gives a trimmed median.
        add_row(cfg_row(REG_MIN_PIXELS, 8'd1));
        add_row(pixel_row(10, 0, 4095, 1'b1));
        add_row(pixel_row(0, 5, 4095, 1'b1));
        add_row(pixel_row(3, 0, 4095, 1'b1));
        add_row(pixel_row(7, 0, 4095, 1'b1));

        // Unused index is ignored; zero length closes a segment on every pixel.
        add_row(cfg_row(REG_UNUSED, 8'd200));
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd0));
        add_row(cfg_row(REG_NOISE_MULTIPLIER, 8'd0));
        add_row(cfg_row(REG_MIN_PIXELS, 8'd0));
        add_row(cfg_row(REG_DROP_HIGH, 8'd0));
        add_row(cfg_row(REG_DROP_LOW, 8'd0));
        add_row(checked_row(0, 1, 0, 1'b1, -1, 1'b1, 1));
        add_row(checked_row(1, 0, 4095, 1'b1, 0, 1'b0, 0));

        // Length lowered below the current position: the next pixel ends the segment.
        add_row(cfg_row(REG_NOISE_MULTIPLIER, 8'd255));
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd8));
        add_row(pixel_row(200, 100, 4095, 1'b1));
        add_row(pixel_row(50, 60, 4095, 1'b1));
        add_row(pixel_row(16383, 16383, 4095, 1'b1));
        add_row(pixel_row(9, 0, 4095, 1'b0));
        add_row(pixel_row(0, 16383, 4095, 1'b1));
        add_row(cfg_row(REG_SEGMENT_LENGTH, 8'd3));
        add_row(pixel_row(7, 7, 4095, 1'b1));

        writing = 1'b0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                if (!writing)
                begin
                    quiesce();
                    writing = 1'b1;
                end
                write_register(directed_rows[r].index, directed_rows[r].data);
            end
            else
            begin
                if (writing)
                begin
                    finish_writes();
                    writing = 1'b0;
                end
                send_pixel(directed_rows[r].pixel, directed_rows[r].typed,
                           directed_rows[r].word);
            end
        end

        // Random phases, each with its own register setting.
        phase = 0;
        long_count = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            quiesce();

            case ($urandom_range(0, 9))
                0:       len_v = 8'd0;
                1:       len_v = 8'd255;
                2:       len_v = 8'(MAX_SEG);
                3:       len_v = 8'($urandom_range(MAX_SEG + 1, 254));
                default: len_v = 8'($urandom_range(1, 16));
            endcase
            if (int'(len_v) >= MAX_SEG && long_count >= LONG_PHASES)
                len_v = 8'($urandom_range(1, 16));
            if (phase == PRESSURE_PHASE)
                len_v = 8'($urandom_range(1, 4));
            case ($urandom_range(0, 9))
                0:       mult_v = 8'd0;
                1:       mult_v = 8'd255;
                default: mult_v = 8'($urandom_range(0, 255));
            endcase
            min_v = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 4));
            case ($urandom_range(0, 7))
                0:       high_v = 8'($urandom_range(0, 255));
                1:       high_v = 8'(MAX_SEG);
                default: high_v = 8'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 7))
                0:       low_v = 8'($urandom_range(0, 255));
                1:       low_v = 8'(MAX_SEG);
                default: low_v = 8'($urandom_range(0, 3));
            endcase

            write_register(REG_SEGMENT_LENGTH, len_v);
            write_register(REG_NOISE_MULTIPLIER, mult_v);
            write_register(REG_MIN_PIXELS, min_v);
            write_register(REG_DROP_HIGH, high_v);
            write_register(REG_DROP_LOW, low_v);
            if ($urandom_range(0, 3) == 0)
                write_register(REG_IDX_W'(REG_UNUSED + $urandom_range(0, 2)),
                               8'($urandom_range(0, 255)));
            finish_writes();

            if (int'(len_v) >= MAX_SEG)
            begin
                long_count++;
                phase_items = MAX_SEG + $urandom_range(0, 8);
            end
            else
                phase_items = $urandom_range(20, 90);

            calm = (phase == CALM_PHASE);
            if (phase == PRESSURE_PHASE)
            begin
                phase_items = 200;
                hold_off_req = 1'b1;
            end

            repeat (phase_items)
            begin
                send_pixel(random_pixel(), 1'b0, '0);
                random_items++;
            end
        end

        // Drain the last results and give the block time to show stray words.
        calm = 1'b0;
        quiesce();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
